### hw/rtl/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Pixel types, sector codes and fixed-point constants shared by the converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hsv2rgb_pkg;

	// Field widths.
	localparam int unsigned HUE_W = 15;
	localparam int unsigned CH_W  = 8;

	// Hue is in 1/64 degree, so one 60-degree sector spans 3840 units.
	localparam int unsigned SECTOR_UNITS = 3840;
	localparam int unsigned HUE_MAX      = 6 * SECTOR_UNITS - 1;
	localparam int unsigned FULL_SCALE   = 255;

	// Reciprocals for exact floor division by a constant.
	// RECIP_255  = ceil(2^24 / 255): exact for products up to 255 * 255.
	// RECIP_3825 = ceil(2^32 / 3825): exact for dividends below 2^20.
	localparam int unsigned RECIP_255  = 65794;
	localparam int unsigned RECIP_3825 = 1122868;

	// Input request: one HSV pixel.
	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [CH_W-1:0]  sat;
		logic [CH_W-1:0]  val;
	} hsv_pixel_t;

	// Output result: one RGB pixel.
	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} rgb_pixel_t;

	// Hue sector, named after the colors at its start and end.
	typedef enum logic [2:0] {
		SEC_RED_YEL  = 3'd0,
		SEC_YEL_GRN  = 3'd1,
		SEC_GRN_CYAN = 3'd2,
		SEC_CYAN_BLU = 3'd3,
		SEC_BLU_MAG  = 3'd4,
		SEC_MAG_RED  = 3'd5
	} sector_t;

endpackage

`default_nettype wire

### hw/rtl/hsv_to_rgb_converter_core.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter core
// Five-stage pipeline converting HSV pixels to 8-bit RGB by the hexcone rule.
// ----------------------------------------------------------------------------
// Usage:
//   An HSV pixel request is taken on the hsv channel when hsv_valid and
//   hsv_ready are both high; the matching RGB pixel is offered on the rgb
//   channel and leaves when rgb_valid and rgb_ready are both high.
//   rgb_valid rises once the pixel reaches the fifth stage, the output
//   register; throughput is one pixel per clock while the receiver does not
//   stall. The stages are clamp and sector search, the weight
//   multiply, the value multiply, the reciprocal divide by 3825 and the
//   channel placement, which feeds the output register.
//   While the receiver stalls with a result waiting, the whole pipeline
//   holds and hsv_ready drops; as soon as the last stage is empty or being
//   taken, the pipeline advances and a new request is taken in the same
//   cycle. Nothing is dropped or repeated.
//   Reset (arst_n low) empties all stages at once; no clearing pass follows
//   and the block takes requests in the first cycle after reset.
//   Results are exact: each channel is the floor of its value over the
//   denominator 255 * 3840.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_converter_core (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    hsv_valid,
	output logic                         hsv_ready,
	input  wire hsv2rgb_pkg::hsv_pixel_t hsv,
	output logic                         rgb_valid,
	input  wire logic                    rgb_ready,
	output hsv2rgb_pkg::rgb_pixel_t      rgb
);

	import hsv2rgb_pkg::*;

	// Pipeline advance: the last stage is empty or its result is taken.
	logic advance;

	// Valid bits of the stages.
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	// Stage 1 payload.
	sector_t             sec_s1;
	logic [11:0]         rem_s1;
	logic [CH_W-1:0]     sat_s1;
	logic [CH_W-1:0]     val_s1;

	// Stage 2 payload.
	sector_t             sec_s2;
	logic [19:0]         wgt_s2;
	logic [15:0]         base_s2;
	logic [CH_W-1:0]     val_s2;

	// Stage 3 payload.
	sector_t             sec_s3;
	logic [27:0]         num_s3;
	logic [32:0]         lo_prod_s3;
	logic [CH_W-1:0]     val_s3;

	// Stage 4 payload.
	sector_t             sec_s4;
	logic [40:0]         mid_prod_s4;
	logic [CH_W-1:0]     lo_s4;
	logic [CH_W-1:0]     val_s4;

	// Stage 5 payload (output register).
	rgb_pixel_t          rgb_s5;

	// Combinational values between the stages.
	logic [HUE_W-1:0]    hue_clamp;
	logic [HUE_W-1:0]    sec_base;
	logic [HUE_W-1:0]    rem_full;
	sector_t             sec_c;
	logic [12:0]         tn_c;
	logic [CH_W-1:0]     inv_sat_c;
	logic [20:0]         wgt_c;
	logic [CH_W-1:0]     mid_c;
	rgb_pixel_t          rgb_c;

	assign advance   = !vld_s5 || rgb_ready;
	assign hsv_ready = advance;
	assign rgb_valid = vld_s5;
	assign rgb       = rgb_s5;

	// Valid bits move with the data whenever the pipeline advances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= hsv_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// Stage 1 logic: clamp the hue and find its sector and remainder.
	always_comb begin
		hue_clamp = (hsv.hue > HUE_W'(HUE_MAX)) ? HUE_W'(HUE_MAX) : hsv.hue;
		if (hue_clamp >= HUE_W'(5 * SECTOR_UNITS)) begin
			sec_c    = SEC_MAG_RED;
			sec_base = HUE_W'(5 * SECTOR_UNITS);
		end else if (hue_clamp >= HUE_W'(4 * SECTOR_UNITS)) begin
			sec_c    = SEC_BLU_MAG;
			sec_base = HUE_W'(4 * SECTOR_UNITS);
		end else if (hue_clamp >= HUE_W'(3 * SECTOR_UNITS)) begin
			sec_c    = SEC_CYAN_BLU;
			sec_base = HUE_W'(3 * SECTOR_UNITS);
		end else if (hue_clamp >= HUE_W'(2 * SECTOR_UNITS)) begin
			sec_c    = SEC_GRN_CYAN;
			sec_base = HUE_W'(2 * SECTOR_UNITS);
		end else if (hue_clamp >= HUE_W'(SECTOR_UNITS)) begin
			sec_c    = SEC_YEL_GRN;
			sec_base = HUE_W'(SECTOR_UNITS);
		end else begin
			sec_c    = SEC_RED_YEL;
			sec_base = '0;
		end
		rem_full = hue_clamp - sec_base;
	end

	// Stage 2 logic: the fraction runs down in odd sectors. The weight is
	// sat * tn + (255 - sat) * 3840, at most 255 * 3840, so 20 bits hold it.
	always_comb begin
		tn_c      = sec_s1[0] ? (13'(SECTOR_UNITS) - {1'b0, rem_s1}) : {1'b0, rem_s1};
		inv_sat_c = ~sat_s1;
		wgt_c     = 21'(sat_s1) * 21'(tn_c) + 21'(inv_sat_c) * 21'(SECTOR_UNITS);
	end

	// Stage 5 logic: the rising or falling channel and the sector placement.
	always_comb begin
		mid_c = mid_prod_s4[39:32];
		unique case (sec_s4)
			SEC_RED_YEL:  rgb_c = '{red: val_s4, green: mid_c,  blue: lo_s4};
			SEC_YEL_GRN:  rgb_c = '{red: mid_c,  green: val_s4, blue: lo_s4};
			SEC_GRN_CYAN: rgb_c = '{red: lo_s4,  green: val_s4, blue: mid_c};
			SEC_CYAN_BLU: rgb_c = '{red: lo_s4,  green: mid_c,  blue: val_s4};
			SEC_BLU_MAG:  rgb_c = '{red: mid_c,  green: lo_s4,  blue: val_s4};
			default:      rgb_c = '{red: val_s4, green: lo_s4,  blue: mid_c};
		endcase
	end

	// Payload registers of all stages.
	always_ff @(posedge clk) begin
		if (advance) begin
			// Stage 1: sector and remainder below 3840.
			sec_s1      <= sec_c;
			rem_s1      <= rem_full[11:0];
			sat_s1      <= hsv.sat;
			val_s1      <= hsv.val;
			// Stage 2: weight and the low-channel product val * (255 - sat).
			sec_s2      <= sec_s1;
			wgt_s2      <= wgt_c[19:0];
			base_s2     <= 16'(val_s1) * 16'(inv_sat_c);
			val_s2      <= val_s1;
			// Stage 3: full numerator and the reciprocal product for the low channel.
			sec_s3      <= sec_s2;
			num_s3      <= 28'(val_s2) * 28'(wgt_s2);
			lo_prod_s3  <= 33'(base_s2) * 33'(RECIP_255);
			val_s3      <= val_s2;
			// Stage 4: divide by 256 * 3825 as a shift and a reciprocal product.
			sec_s4      <= sec_s3;
			mid_prod_s4 <= 41'(num_s3[27:8]) * 41'(RECIP_3825);
			lo_s4       <= lo_prod_s3[31:24];
			val_s4      <= val_s3;
			// Stage 5: output register.
			rgb_s5      <= rgb_c;
		end
	end

	// A request that meets no stall while it passes the stages arrives at the output.
	assert property (@(posedge clk) disable iff (!arst_n)
		(hsv_valid && hsv_ready) ##1 hsv_ready ##1 hsv_ready ##1 hsv_ready
			##1 hsv_ready |=> rgb_valid)
		else $error("pixel request did not reach the output in five cycles");

	// The remainder after the sector search always lies inside one sector.
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (rem_s1 < 12'(SECTOR_UNITS)))
		else $error("hue remainder out of sector range");

	// The low channel never exceeds the value.
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> (lo_s4 <= val_s4))
		else $error("low channel above value");

	// The moving channel lies between the low channel and the value.
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> ((mid_c >= lo_s4) && (mid_c <= val_s4)))
		else $error("moving channel outside its bounds");

endmodule

`default_nettype wire

### test/hsv_to_rgb_converter_core_test.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter core testbench
// Streams HSV pixel requests through the converter under random sender bursts
// and receiver stalls, and checks every RGB result against an exact
// fixed-point prediction of the hexcone rule, in order.
// ----------------------------------------------------------------------------

module hsv_to_rgb_converter_core_test;

	timeunit 1ns;
	timeprecision 1ps;

	import hsv2rgb_pkg::*;

	localparam int unsigned RANDOM_PIXELS = 440;
	localparam int unsigned LONG_HOLD     = 80;
	localparam int unsigned HOLD_AFTER    = 300;
	localparam int unsigned STALL_LIMIT   = 2000;
	localparam int unsigned TAIL_CYCLES   = 10;
	localparam int unsigned REPORT_LIMIT  = 10;

	// One accepted request together with the pixel it must produce.
	typedef struct {
		hsv_pixel_t src;
		rgb_pixel_t want;
	} conversion_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       hsv_valid = 1'b0;
	logic       hsv_ready;
	hsv_pixel_t hsv = '0;
	logic       rgb_valid;
	logic       rgb_ready = 1'b0;
	rgb_pixel_t rgb;

	hsv_pixel_t  pending_pixels[$];
	conversion_t expected_rgb[$];

	int unsigned mismatch_count = 0;
	int unsigned results_seen = 0;
	int unsigned idle_cycles = 0;

	int unsigned burst_left;
	int unsigned gap_left;
	int unsigned hold_left;
	logic        hold_done;
	int unsigned ready_pct;
	int unsigned pattern_left;

	hsv_to_rgb_converter_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.hsv_valid (hsv_valid),
		.hsv_ready (hsv_ready),
		.hsv       (hsv),
		.rgb_valid (rgb_valid),
		.rgb_ready (rgb_ready),
		.rgb       (rgb)
	);

	// Clock generation, 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Exact hexcone conversion over the common denominator 255 * 3840.
	function automatic rgb_pixel_t hsv_to_rgb(input hsv_pixel_t px);
		int unsigned     h;
		int unsigned     rem;
		int unsigned     weight;
		sector_t         sec;
		longint unsigned v;
		longint unsigned s;
		longint unsigned floor_scaled;
		logic [CH_W-1:0] top;
		logic [CH_W-1:0] bottom;
		logic [CH_W-1:0] ramp;
		rgb_pixel_t      c;
		h = px.hue;
		if (h > HUE_MAX) begin
			h = HUE_MAX;
		end
		sec = sector_t'(h / SECTOR_UNITS);
		rem = h % SECTOR_UNITS;
		// Odd sectors fall instead of rise across the sector.
		weight = (sec[0]) ? (SECTOR_UNITS - rem) : rem;
		v = px.val;
		s = px.sat;
		floor_scaled = v * (FULL_SCALE - s) * SECTOR_UNITS;
		top = px.val;
		bottom = CH_W'(floor_scaled / (FULL_SCALE * SECTOR_UNITS));
		ramp = CH_W'((v * s * weight + floor_scaled) / (FULL_SCALE * SECTOR_UNITS));
		case (sec)
			SEC_RED_YEL: begin
				c = '{red: top, green: ramp, blue: bottom};
			end
			SEC_YEL_GRN: begin
				c = '{red: ramp, green: top, blue: bottom};
			end
			SEC_GRN_CYAN: begin
				c = '{red: bottom, green: top, blue: ramp};
			end
			SEC_CYAN_BLU: begin
				c = '{red: bottom, green: ramp, blue: top};
			end
			SEC_BLU_MAG: begin
				c = '{red: ramp, green: bottom, blue: top};
			end
			default: begin
				c = '{red: top, green: bottom, blue: ramp};
			end
		endcase
		return c;
	endfunction

	// Counts a failure and prints only the first few.
	task automatic log_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT) begin
			$display("%s", what);
		end
	endtask

	task automatic queue_pixel(input int unsigned h, input int unsigned s, input int unsigned v);
		hsv_pixel_t px;
		px.hue = HUE_W'(h);
		px.sat = CH_W'(s);
		px.val = CH_W'(v);
		pending_pixels.push_back(px);
	endtask

	// Random pixels, weighted toward sector edges, the clamp range and extreme levels.
	task automatic queue_random(input int unsigned count);
		int unsigned h;
		int unsigned s;
		int unsigned v;
		repeat (count) begin
			case ($urandom_range(0, 9))
				0: h = $urandom_range(HUE_MAX + 1, (1 << HUE_W) - 1);
				1: h = $urandom_range(0, (1 << HUE_W) - 1);
				2: h = $urandom_range(0, 5) * SECTOR_UNITS
					+ ($urandom_range(0, 1) ? 0 : SECTOR_UNITS - 1);
				default: h = $urandom_range(0, HUE_MAX);
			endcase
			case ($urandom_range(0, 9))
				0: s = 0;
				1: s = FULL_SCALE;
				default: s = $urandom_range(0, FULL_SCALE);
			endcase
			case ($urandom_range(0, 9))
				0: v = 0;
				1: v = FULL_SCALE;
				default: v = $urandom_range(0, FULL_SCALE);
			endcase
			queue_pixel(h, s, v);
		end
	endtask

	// Waits until every request is taken and every result has come back.
	task automatic drain_all();
		while (pending_pixels.size() != 0 || hsv_valid) begin
			@(posedge clk);
		end
		while (expected_rgb.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Request driver: bursts of random length separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hsv_valid <= 1'b0;
			hsv <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!hsv_valid || hsv_ready) begin
			if (gap_left != 0) begin
				hsv_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_pixels.size() != 0) begin
				hsv <= pending_pixels.pop_front();
				hsv_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				hsv_valid <= 1'b0;
			end
		end
	end

	// Result receiver: the ready pattern changes duty at random intervals,
	// and once HOLD_AFTER results have been taken it holds ready low for one long hold.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rgb_ready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
			ready_pct <= 100;
			pattern_left <= 0;
		end else if (hold_left != 0) begin
			rgb_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && results_seen >= HOLD_AFTER) begin
			rgb_ready <= 1'b0;
			hold_left <= LONG_HOLD - 1;
			hold_done <= 1'b1;
		end else begin
			if (pattern_left == 0) begin
				case ($urandom_range(0, 3))
					0: ready_pct <= 100;
					1: ready_pct <= 80;
					2: ready_pct <= 50;
					default: ready_pct <= 15;
				endcase
				pattern_left <= $urandom_range(16, 96);
			end else begin
				pattern_left <= pattern_left - 1;
			end
			rgb_ready <= ($urandom_range(1, 100) <= ready_pct);
		end
	end

	// Monitor: predicts on each accepted request and checks each accepted result.
	always @(posedge clk) begin : monitor_proc
		conversion_t entry;
		if (arst_n) begin
			if (hsv_valid && hsv_ready) begin
				entry.src = hsv;
				entry.want = hsv_to_rgb(hsv);
				expected_rgb.push_back(entry);
			end
			if (rgb_valid && rgb_ready) begin
				results_seen <= results_seen + 1;
				if (expected_rgb.size() == 0) begin
					log_mismatch($sformatf("unexpected rgb result %0d %0d %0d",
						rgb.red, rgb.green, rgb.blue));
				end else begin
					entry = expected_rgb.pop_front();
					if (rgb.red !== entry.want.red || rgb.green !== entry.want.green
						|| rgb.blue !== entry.want.blue) begin
						log_mismatch($sformatf(
							"hsv %0d/%0d/%0d: expected rgb %0d %0d %0d, got %0d %0d %0d",
							entry.src.hue, entry.src.sat, entry.src.val,
							entry.want.red, entry.want.green, entry.want.blue,
							rgb.red, rgb.green, rgb.blue));
					end
				end
			end
			if ((hsv_valid && hsv_ready) || (rgb_valid && rgb_ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Watchdog: ends the run when nothing moves for too long.
	always @(posedge clk) begin
		if (idle_cycles >= STALL_LIMIT) begin
			$display("hsv_to_rgb_converter_core_test failed");
			$finish;
		end
	end

	// Stimulus sequence and end of run.
	initial begin
		// Sector edges, clamp range and the saturation and value extremes.
		queue_pixel(0, 255, 255);
		queue_pixel(3839, 255, 255);
		queue_pixel(3840, 255, 255);
		queue_pixel(7679, 255, 255);
		queue_pixel(7680, 200, 255);
		queue_pixel(11520, 255, 180);
		queue_pixel(15360, 128, 255);
		queue_pixel(19200, 255, 77);
		queue_pixel(1920, 255, 255);
		queue_pixel(5760, 160, 200);
		queue_pixel(9600, 90, 250);
		queue_pixel(13440, 255, 1);
		queue_pixel(17280, 1, 255);
		queue_pixel(21120, 128, 128);
		queue_pixel(23039, 255, 255);
		queue_pixel(23040, 255, 255);
		queue_pixel(32767, 200, 150);
		queue_pixel(12345, 0, 200);
		queue_pixel(32767, 0, 255);
		queue_pixel(5000, 255, 0);
		queue_pixel(0, 0, 0);
		queue_pixel(32767, 255, 255);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// The sender pauses between phases until the pipeline is empty.
		drain_all();
		queue_random(RANDOM_PIXELS);
		drain_all();
		queue_random(RANDOM_PIXELS);
		drain_all();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("hsv_to_rgb_converter_core_test passed");
		end else begin
			$display("hsv_to_rgb_converter_core_test failed");
		end
		$finish;
	end

endmodule

### files.f
hw/rtl/hsv2rgb_pkg.sv
hw/rtl/hsv_to_rgb_converter_core.sv
test/hsv_to_rgb_converter_core_test.sv
